FILE: design/cse_pkg.sv
// Shared types and constants for the Chebyshev series evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cse_pkg;

  // Field widths and fixed-point format
  localparam int COEF_BITS = 48;               // coefficient width, signed
  localparam int FRAC_BITS = 30;               // fraction bits of time and T values
  localparam int TIME_BITS = 32;               // time and T value width, signed
  localparam int ACC_BITS  = 56;               // result width, signed

  // The coefficient product is split into two halves on the shared multiplier
  localparam int LO_BITS    = COEF_BITS / 2;   // low half, taken unsigned
  localparam int HI_BITS    = COEF_BITS - LO_BITS;
  localparam int MUL_A_BITS = TIME_BITS + 1;   // holds time, unsigned low half, signed high half
  localparam int PROD_BITS  = MUL_A_BITS + TIME_BITS;
  localparam int FULL_BITS  = COEF_BITS + TIME_BITS;   // exact coefficient * T
  localparam int TERM_BITS  = FULL_BITS - FRAC_BITS;   // scaled term
  localparam int SUM_BITS   = ((TERM_BITS > ACC_BITS) ? TERM_BITS : ACC_BITS) + 1;

  // Recurrence: (t * T(k-1)) >>> (FRAC_BITS-1), then minus T(k-2)
  localparam int REC_BITS  = 2 * TIME_BITS - FRAC_BITS + 1;
  localparam int DIFF_BITS = REC_BITS + 1;

  localparam logic signed [TIME_BITS-1:0] T_ONE = TIME_BITS'(1) <<< FRAC_BITS;
  localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0]  A_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  A_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // Which term comes next in the open series
  typedef enum logic [1:0] {
    PH_IDLE,   // no series open
    PH_T1,     // next term is T1 = t
    PH_TN      // next term comes from the recurrence
  } phase_e;

  // Operand pairing of the shared multiplier
  typedef enum logic [1:0] {
    MUL_HOLD,  // keep the last product
    MUL_REC,   // t * T(k-1)
    MUL_LO,    // low coefficient half * T(k)
    MUL_HI     // high coefficient half * T(k)
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_MUL,
    ST_REC_FIX,
    ST_LO_MUL,
    ST_HI_MUL,
    ST_ADD,
    ST_ACC
  } state_e;

  // Status into the sequencer
  typedef struct packed {
    logic   in_valid;
    logic   first;
    phase_e phase;
    logic   last;        // latched last flag of the item in work
    logic   out_blocked; // output register full and stalled
  } seq_stat_t;

  // Controls out of the sequencer
  typedef struct packed {
    logic    in_ready;
    logic    accept;
    logic    rec_fix;
    mul_op_e mul_op;
    logic    sum_lo;
    logic    sum_hi;
    logic    acc_upd;
  } seq_ctrl_t;

endpackage

FILE: design/cse_mul.sv
// Shared signed multiplier with operand select and registered product.
// Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_mul (
  input  logic                                  clk_i,
  input  cse_pkg::mul_op_e                      op_i,
  input  logic signed [cse_pkg::TIME_BITS-1:0]  time_i,
  input  logic signed [cse_pkg::TIME_BITS-1:0]  prev_i,
  input  logic signed [cse_pkg::COEF_BITS-1:0]  coef_i,
  input  logic signed [cse_pkg::TIME_BITS-1:0]  tk_i,
  output logic signed [cse_pkg::PROD_BITS-1:0]  product_o
);
  import cse_pkg::*;

  logic signed [MUL_A_BITS-1:0] a_op;
  logic signed [TIME_BITS-1:0]  b_op;
  logic signed [PROD_BITS-1:0]  product_d, product_q;

  always_comb begin
    a_op = MUL_A_BITS'(time_i);
    b_op = tk_i;
    unique case (op_i)
      MUL_REC: begin
        a_op = MUL_A_BITS'(time_i);
        b_op = prev_i;
      end
      MUL_LO: begin
        // low half is magnitude only: zero-extend
        a_op = signed'(MUL_A_BITS'({1'b0, coef_i[LO_BITS-1:0]}));
      end
      MUL_HI: begin
        a_op = MUL_A_BITS'(signed'(coef_i[COEF_BITS-1:LO_BITS]));
      end
      default: begin
        a_op = MUL_A_BITS'(time_i);
      end
    endcase
    product_d = (op_i == MUL_HOLD) ? product_q : a_op * b_op;
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign product_o = product_q;

endmodule

FILE: design/cse_seq.sv
// Sequencer: per term, recurrence (past T1), two multiplies, add and accumulate.
// Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cse_pkg::seq_stat_t stat_i,
  output cse_pkg::seq_ctrl_t ctrl_o
);
  import cse_pkg::*;

  state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    ctrl_o.mul_op  = MUL_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          ctrl_o.accept = 1'b1;
          if (stat_i.first || stat_i.phase == PH_T1) begin
            state_d = ST_LO_MUL;
          end else if (stat_i.phase == PH_TN) begin
            state_d = ST_REC_MUL;
          end
          // no open series and not first: item is dropped
        end
      end
      ST_REC_MUL: begin
        ctrl_o.mul_op = MUL_REC;
        state_d       = ST_REC_FIX;
      end
      ST_REC_FIX: begin
        ctrl_o.rec_fix = 1'b1;
        state_d        = ST_LO_MUL;
      end
      ST_LO_MUL: begin
        ctrl_o.mul_op = MUL_LO;
        state_d       = ST_HI_MUL;
      end
      ST_HI_MUL: begin
        ctrl_o.mul_op = MUL_HI;
        ctrl_o.sum_lo = 1'b1;
        state_d       = ST_ADD;
      end
      ST_ADD: begin
        ctrl_o.sum_hi = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        if (!(stat_i.last && stat_i.out_blocked)) begin
          ctrl_o.acc_upd = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/chebyshev_series_evaluator.sv
// Top level of the Chebyshev series evaluator: term state, accumulator, output register.
// Depends on cse_pkg, cse_mul and cse_seq.
`timescale 1ns / 1ps
//
//   channel | signals                                        | dir | transfer when
//   --------+------------------------------------------------+-----+------------------------
//   in      | in_valid_i, in_stall_o, coefficient_i,         | in  | in_valid_i & !in_stall_o
//           | norm_time_i, first_i, last_i                   |     |
//   out     | out_valid_o, out_stall_i, series_value_o,      | out | out_valid_o & !out_stall_i
//           | saturated_o                                    |     |
//
// Term zero and T1 need no recurrence; for later terms the sequencer first runs the
// recurrence product t*T(k-1) through the single shared 33x32 multiplier, which
// then takes the coefficient in two halves.
// An item with no open series and no first flag is taken and dropped.
// in_stall_o is high while a term is in work. A finished sum waits in the output
// register; the next term is taken meanwhile, and only the accumulate step of a
// further last term waits for that register to drain.
// Reset is asynchronous, active low, and clears series state, not payload registers.

module chebyshev_series_evaluator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cse_pkg::COEF_BITS-1:0]  coefficient_i,
  input  logic signed [cse_pkg::TIME_BITS-1:0]  norm_time_i,
  input  logic                                  first_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cse_pkg::ACC_BITS-1:0]   series_value_o,
  output logic                                  saturated_o
);
  import cse_pkg::*;

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  // series state
  logic signed [TIME_BITS-1:0] time_d, time_q;
  logic signed [TIME_BITS-1:0] prev_d, prev_q;      // T(k-1)
  logic signed [TIME_BITS-1:0] prev2_d, prev2_q;    // T(k-2)
  logic signed [TIME_BITS-1:0] tk_d, tk_q;          // current T(k)
  phase_e                      phase_d, phase_q;
  logic signed [ACC_BITS-1:0]  acc_d, acc_q;
  logic                        ovf_d, ovf_q;
  // item in work
  logic signed [COEF_BITS-1:0] coef_d, coef_q;
  logic                        last_d, last_q;
  logic signed [FULL_BITS-1:0] sum_d, sum_q;        // exact coefficient * T(k)
  // output register
  logic                        out_valid_d, out_valid_q;
  logic signed [ACC_BITS-1:0]  out_value_d, out_value_q;
  logic                        out_sat_d, out_sat_q;

  logic signed [PROD_BITS-1:0] product;

  // recurrence and accumulate datapath
  logic signed [REC_BITS-1:0]  rec;
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-TIME_BITS:0] diff_top;
  logic                        diff_fits;
  logic signed [TIME_BITS-1:0] t_next;
  logic signed [TERM_BITS-1:0] term;
  logic signed [SUM_BITS-1:0]  acc_sum;
  logic [SUM_BITS-ACC_BITS:0]  sum_top;
  logic                        sum_fits;
  logic signed [ACC_BITS-1:0]  acc_next;

  cse_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  cse_mul u_mul (
    .clk_i     (clk_i),
    .op_i      (ctrl.mul_op),
    .time_i    (time_q),
    .prev_i    (prev_q),
    .coef_i    (coef_q),
    .tk_i      (tk_q),
    .product_o (product)
  );

  assign stat.in_valid    = in_valid_i;
  assign stat.first       = first_i;
  assign stat.phase       = phase_q;
  assign stat.last        = last_q;
  assign stat.out_blocked = out_valid_q && out_stall_i;

  // T(k) = sat32(((t * T(k-1)) >>> (FRAC_BITS-1)) - T(k-2)); floor shift
  assign rec       = REC_BITS'(product[2*TIME_BITS-1:0] >>> (FRAC_BITS - 1));
  assign diff      = DIFF_BITS'(rec) - DIFF_BITS'(prev2_q);
  assign diff_top  = diff[DIFF_BITS-1:TIME_BITS-1];
  assign diff_fits = (&diff_top) || !(|diff_top);
  assign t_next    = diff_fits ? TIME_BITS'(diff)
                   : (diff[DIFF_BITS-1] ? T_MIN : T_MAX);

  // floor(c*T / 2^FRAC_BITS) added with saturation to the result range
  assign term     = TERM_BITS'(sum_q >>> FRAC_BITS);
  assign acc_sum  = SUM_BITS'(acc_q) + SUM_BITS'(term);
  assign sum_top  = acc_sum[SUM_BITS-1:ACC_BITS-1];
  assign sum_fits = (&sum_top) || !(|sum_top);
  assign acc_next = sum_fits ? ACC_BITS'(acc_sum)
                  : (acc_sum[SUM_BITS-1] ? A_MIN : A_MAX);

  always_comb begin
    time_d      = time_q;
    prev_d      = prev_q;
    prev2_d     = prev2_q;
    tk_d        = tk_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    coef_d      = coef_q;
    last_d      = last_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_sat_d   = out_sat_q;

    if (ctrl.accept) begin
      coef_d = coefficient_i;
      last_d = last_i;
      if (first_i) begin
        // term zero: T0 = 1.0, new series
        time_d  = norm_time_i;
        acc_d   = '0;
        ovf_d   = 1'b0;
        tk_d    = T_ONE;
        prev2_d = '0;
        prev_d  = T_ONE;
        phase_d = PH_T1;
      end else if (phase_q == PH_T1) begin
        tk_d    = time_q;
        prev2_d = prev_q;
        prev_d  = time_q;
        phase_d = PH_TN;
      end
    end

    if (ctrl.rec_fix) begin
      tk_d    = t_next;
      prev2_d = prev_q;
      prev_d  = t_next;
      if (!diff_fits) begin
        ovf_d = 1'b1;
      end
    end

    if (ctrl.sum_lo) begin
      sum_d = FULL_BITS'(product);
    end
    if (ctrl.sum_hi) begin
      sum_d = sum_q + (FULL_BITS'(product) <<< LO_BITS);
    end

    if (ctrl.acc_upd) begin
      acc_d = acc_next;
      if (!sum_fits) begin
        ovf_d = 1'b1;
      end
      if (last_q) begin
        out_valid_d = 1'b1;
        out_value_d = acc_next;
        out_sat_d   = ovf_q || !sum_fits;
        phase_d     = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      prev_q      <= '0;
      prev2_q     <= '0;
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      prev_q      <= prev_d;
      prev2_q     <= prev2_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tk_q        <= tk_d;
    coef_q      <= coef_d;
    last_q      <= last_d;
    sum_q       <= sum_d;
    out_value_q <= out_value_d;
    out_sat_q   <= out_sat_d;
  end

  assign in_stall_o     = !ctrl.in_ready;
  assign out_valid_o    = out_valid_q;
  assign series_value_o = out_value_q;
  assign saturated_o    = out_sat_q;

endmodule

FILE: bench/chebyshev_series_evaluator_tb.sv
// Testbench for chebyshev_series_evaluator: directed and random Chebyshev series,
// checked against a cycle-free predictor of the fixed-point sum and overflow flag.
// Depends on cse_pkg and the chebyshev_series_evaluator RTL.
`timescale 1ns / 1ps

module chebyshev_series_evaluator_tb;
  import cse_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_TERMS = 200;   // random terms that reach an open series
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 20;    // settle time after the last sum arrived
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [COEF_BITS-1:0] C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [TIME_BITS-1:0] T_HALF = T_ONE >>> 1;

  // One finished series as the block should report it
  typedef struct packed {
    logic signed [ACC_BITS-1:0] value;
    logic                       sat;
  } series_sum_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [COEF_BITS-1:0]  coefficient_i;
  logic signed [TIME_BITS-1:0]  norm_time_i;
  logic                         first_i;
  logic                         last_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [ACC_BITS-1:0]   series_value_o;
  logic                         saturated_o;

  // Predicted series state, updated once per accepted input transfer
  logic signed [TIME_BITS-1:0]  series_time  = '0;
  logic signed [TIME_BITS-1:0]  poly_km1     = '0;   // T(k-1)
  logic signed [TIME_BITS-1:0]  poly_km2     = '0;   // T(k-2)
  phase_e                       series_phase = PH_IDLE;
  logic signed [ACC_BITS-1:0]   series_sum   = '0;
  logic                         series_sat   = 1'b0;

  series_sum_t  sums_due[$];        // sums still owed by the block, oldest first
  int unsigned  terms_counted = 0;  // terms that landed in an open series
  int unsigned  mismatches    = 0;
  bit           no_idle       = 1'b0; // when set, neither side inserts gaps

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  chebyshev_series_evaluator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .coefficient_i  (coefficient_i),
    .norm_time_i    (norm_time_i),
    .first_i        (first_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .series_value_o (series_value_o),
    .saturated_o    (saturated_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advance the series by one accepted term. T0 = 1.0, T1 = t, then
  // Tk = floor(2*t*T(k-1)) - T(k-2) clamped to 32 bits. Each term adds
  // floor(c*Tk / 2^FRAC_BITS) to a sum clamped to 56 bits. Either clamp sets
  // the flag. A term with no open series and no first flag is dropped.
  function automatic void advance_series(input logic signed [COEF_BITS-1:0] coef,
                                         input logic signed [TIME_BITS-1:0] t_in,
                                         input logic is_first, input logic is_last);
    logic signed [TIME_BITS-1:0]           tk;
    longint                                rec;
    logic signed [COEF_BITS+TIME_BITS-1:0] prod;
    longint                                sum;
    if (is_first) begin
      // New series; any open one is abandoned without a result
      series_time  = t_in;
      series_sum   = '0;
      series_sat   = 1'b0;
      tk           = T_ONE;
      poly_km2     = '0;
      poly_km1     = tk;
      series_phase = PH_T1;
    end else if (series_phase == PH_IDLE) begin
      return;
    end else if (series_phase == PH_T1) begin
      tk           = series_time;
      poly_km2     = poly_km1;
      poly_km1     = tk;
      series_phase = PH_TN;
    end else begin
      // Shift by FRAC_BITS-1 folds in the factor of two
      rec = ((longint'(series_time) * longint'(poly_km1)) >>> (FRAC_BITS - 1))
            - longint'(poly_km2);
      if (rec > longint'(T_MAX)) begin
        tk = T_MAX;
        series_sat = 1'b1;
      end else if (rec < longint'(T_MIN)) begin
        tk = T_MIN;
        series_sat = 1'b1;
      end else begin
        tk = TIME_BITS'(rec);
      end
      poly_km2 = poly_km1;
      poly_km1 = tk;
    end
    terms_counted++;

    // Exact product, floor shift; magnitude stays far below the term clamp
    prod = coef * tk;
    sum  = longint'(series_sum) + longint'(prod >>> FRAC_BITS);
    if (sum > longint'(A_MAX)) begin
      series_sum = A_MAX;
      series_sat = 1'b1;
    end else if (sum < longint'(A_MIN)) begin
      series_sum = A_MIN;
      series_sat = 1'b1;
    end else begin
      series_sum = ACC_BITS'(sum);
    end

    if (is_last) begin
      sums_due.push_back('{value: series_sum, sat: series_sat});
      series_phase = PH_IDLE;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Mix of full-width noise, small values, extremes and 32-bit values
  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return COEF_BITS'({$urandom(), $urandom()});
    if (pick < 6) return COEF_BITS'($signed($urandom_range(0, 2000)) - 1000);
    if (pick < 7) return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
    return COEF_BITS'($signed($urandom()));
  endfunction

  // Mostly in [-1.0, +1.0]; some exact endpoints; some anywhere in 32 bits
  function automatic logic signed [TIME_BITS-1:0] rand_time();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      return TIME_BITS'($urandom_range(0, 32'd1 << (FRAC_BITS + 1)) - (32'd1 << FRAC_BITS));
    if (pick == 7) return ($urandom_range(0, 1) != 0) ? T_ONE : -T_ONE;
    return TIME_BITS'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Entered and left at a rising edge. Valid stays high across back-to-back
  // terms, so it is lowered only when a gap is drawn.
  task automatic send_term(input logic signed [COEF_BITS-1:0] coef,
                           input logic signed [TIME_BITS-1:0] t,
                           input logic is_first, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coefficient_i <= coef;
    norm_time_i   <= t;
    first_i       <= is_first;
    last_i        <= is_last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    advance_series(coef, t, is_first, is_last);
  endtask

  // Series of one coefficient repeated; close marks the final term last
  task automatic send_series(input logic signed [TIME_BITS-1:0] t, input int len,
                             input logic signed [COEF_BITS-1:0] coef, input bit close);
    for (int k = 0; k < len; k++)
      send_term(coef, t, k == 0, close && (k == len - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each transfer, then the check
  // ---------------------------------------------------------------------------

  initial begin : drain_side
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_sums
    series_sum_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("sum with none pending: value %0d sat %0b", series_value_o, saturated_o);
      end else begin
        want = sums_due.pop_front();
        if (series_value_o !== want.value || saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("series sum mismatch: expected %0d sat %0b, got %0d sat %0b",
                     want.value, want.sat, series_value_o, saturated_o);
        end
      end
    end
  end

  // Hang detection: any run of cycles with no transfer on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Terms with no open series are dropped, a last flag included
  task automatic test_stray_terms();
    send_term(C_MAX, T_ONE, 1'b0, 1'b0);
    send_term(C_MIN, -T_ONE, 1'b0, 1'b1);
  endtask

  // First and last together: the sum is just c * 1.0
  task automatic test_single_terms();
    send_term(C_MAX, T_MIN, 1'b1, 1'b1);
    send_term(C_MIN, T_MAX, 1'b1, 1'b1);
    send_term('0, '0, 1'b1, 1'b1);
    send_term(COEF_BITS'(-1), T_ONE, 1'b1, 1'b1);
  endtask

  // Time at the ends of [-1,+1] and beyond it, where T clamps in both directions
  task automatic test_time_extremes();
    send_series(T_ONE, 3, C_MAX, 1'b1);
    send_series(-T_ONE, 3, C_MIN, 1'b1);
    send_series(T_MAX, 4, C_MAX, 1'b1);
    send_series(T_MIN, 4, C_MIN, 1'b1);
  endtask

  // A first flag in the middle of a series drops it and starts over
  task automatic test_restart();
    send_term(C_MAX, T_HALF, 1'b1, 1'b0);
    send_term(rand_coef(), '0, 1'b0, 1'b0);
    send_term(rand_coef(), -T_HALF, 1'b1, 1'b0);
    send_term(rand_coef(), '0, 1'b0, 1'b0);
    send_term(rand_coef(), '0, 1'b0, 1'b1);
  endtask

  // Long series with T clamped near 2.0 and extreme coefficients drive the
  // sum into both clamps; run without gaps to keep it short
  task automatic test_sum_clamp();
    no_idle = 1'b1;
    send_series(T_MAX, 140, C_MAX, 1'b1);
    send_series(T_MAX, 140, C_MIN, 1'b1);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed series of random length; some left open so the next
  // first drops them, and a few stray terms as noise
  task automatic test_random_series();
    int unsigned                 start_count;
    int unsigned                 pick;
    int unsigned                 len;
    bit                          open_end;
    logic signed [TIME_BITS-1:0] t;
    start_count = terms_counted;
    while (terms_counted - start_count < RANDOM_TERMS) begin
      if ($urandom_range(0, 15) == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_term(rand_coef(), rand_time(), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        open_end = (pick < 4);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        t = rand_time();
        for (int k = 0; k < len; k++)
          send_term(rand_coef(), (k == 0) ? t : rand_time(), k == 0,
                    !open_end && (k == len - 1));
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    coefficient_i = '0;
    norm_time_i   = '0;
    first_i       = 1'b0;
    last_i        = 1'b0;
    out_stall_i   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_stray_terms();
    test_single_terms();
    test_time_extremes();
    test_restart();
    test_sum_clamp();
    test_random_series();
    in_valid_i <= 1'b0;

    // All sums in, then a settle time to catch anything extra
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && sums_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
